### src/sse_pkg.sv
// Shared types and codes for the sparse set engine.
// No dependencies; sse_ctrl, sse_dpath and the top level import this package.
package sse_pkg;

  localparam int ID_W    = 10;
  localparam int POS_W   = 10;
  localparam int COUNT_W = 11;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_TEST   = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [ID_W-1:0]  item_id;
    logic [POS_W-1:0] read_pos;
  } in_item_t;

  typedef struct packed {
    logic               was_member;
    logic [COUNT_W-1:0] element_count;
    logic [POS_W-1:0]   slot_index;
    logic [ID_W-1:0]    read_id;
    logic               read_valid;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic fire;
    logic clr;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic clr_last;
  } ctl_sts_t;

endpackage

### src/sse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/sse_ctrl.sv
// Sequencing controller: clearing pass, accept, and result issue.
// Depends on sse_pkg.
module sse_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sse_pkg::ctl_sts_t sts,
  output sse_pkg::ctl_cmd_t cmd
);
  import sse_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!sts.out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign cmd.load = (state_r == S_IDLE) && in_valid;
  assign cmd.fire = (state_r == S_LOOK) && !sts.out_busy;
  assign cmd.clr  = (state_r == S_CLEAR);

endmodule

### src/sse_dpath.sv
// Datapath: membership, position map and dense list memories, count,
// result register. Depends on sse_pkg and sse_ram.
module sse_dpath #(
  parameter int ID_SPACE = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sse_pkg::ctl_cmd_t   cmd,
  output sse_pkg::ctl_sts_t   sts,
  input  sse_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output sse_pkg::out_item_t  out_item
);
  import sse_pkg::*;

  localparam int IW = $clog2(ID_SPACE);
  localparam int CW = $clog2(ID_SPACE + 1);

  logic [1:0]       mode_r;
  logic [ID_W-1:0]  id_r;
  logic [POS_W-1:0] pos_r;
  logic             in_range_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    clr_addr_r;
  logic             out_valid_r;
  out_item_t        out_r, out_nxt;

  logic [IW-1:0]   id_addr;
  logic            mem_rd;
  logic [IW-1:0]   map_rd;
  logic [ID_W-1:0] dense_rd;

  logic            member, ins_new, rem_hit, rd_ok;
  logic            mem_we, mem_wdata;
  logic [IW-1:0]   mem_waddr;
  logic            map_we;
  logic [IW-1:0]   map_waddr, map_wdata;
  logic            dense_we;
  logic [IW-1:0]   dense_waddr, dense_raddr;
  logic [ID_W-1:0] dense_wdata;

  assign id_addr = IW'(id_r);
  assign dense_raddr = (in_item.mode == MODE_READ) ? IW'(in_item.read_pos)
                                                   : IW'(count_r - CW'(1));

  sse_ram #(.WIDTH(1), .DEPTH(ID_SPACE)) u_member (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (cmd.load),
    .raddr(IW'(in_item.item_id)),
    .rdata(mem_rd)
  );

  sse_ram #(.WIDTH(IW), .DEPTH(ID_SPACE)) u_map (
    .clk  (clk),
    .we   (map_we),
    .waddr(map_waddr),
    .wdata(map_wdata),
    .re   (cmd.load),
    .raddr(IW'(in_item.item_id)),
    .rdata(map_rd)
  );

  sse_ram #(.WIDTH(ID_W), .DEPTH(ID_SPACE)) u_dense (
    .clk  (clk),
    .we   (dense_we),
    .waddr(dense_waddr),
    .wdata(dense_wdata),
    .re   (cmd.load),
    .raddr(dense_raddr),
    .rdata(dense_rd)
  );

  always_comb begin
    member  = mem_rd && in_range_r;
    ins_new = (mode_r == MODE_INSERT) && !member && in_range_r
              && (32'(count_r) < ID_SPACE);
    rem_hit = (mode_r == MODE_REMOVE) && member && (count_r != '0);
    rd_ok   = (mode_r == MODE_READ) && (32'(pos_r) < 32'(count_r))
              && (32'(pos_r) < ID_SPACE);

    mem_we    = cmd.clr || (cmd.fire && (ins_new || rem_hit));
    mem_waddr = cmd.clr ? clr_addr_r : id_addr;
    mem_wdata = !cmd.clr && ins_new;

    map_we    = cmd.fire && (ins_new || (rem_hit && (dense_rd != id_r)));
    map_waddr = ins_new ? id_addr : IW'(dense_rd);
    map_wdata = ins_new ? IW'(count_r) : map_rd;

    dense_we    = cmd.fire && (ins_new || rem_hit);
    dense_waddr = ins_new ? IW'(count_r) : map_rd;
    dense_wdata = ins_new ? id_r : dense_rd;

    count_nxt = count_r;
    if (cmd.fire && ins_new) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.fire && rem_hit) begin
      count_nxt = count_r - CW'(1);
    end

    out_nxt               = '0;
    out_nxt.element_count = COUNT_W'(count_nxt);
    case (mode_r)
      MODE_INSERT: begin
        out_nxt.was_member = member;
        if (member) begin
          out_nxt.slot_index = POS_W'(map_rd);
        end else if (ins_new) begin
          out_nxt.slot_index = POS_W'(count_r);
        end
      end
      MODE_REMOVE: begin
        out_nxt.was_member = member;
      end
      MODE_TEST: begin
        out_nxt.was_member = member;
        if (member) begin
          out_nxt.slot_index = POS_W'(map_rd);
        end
      end
      MODE_READ: begin
        out_nxt.read_valid = rd_ok;
        out_nxt.read_id    = rd_ok ? dense_rd : '0;
      end
      default: out_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + IW'(1);
      end
      if (cmd.fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r     <= in_item.mode;
      id_r       <= in_item.item_id;
      pos_r      <= in_item.read_pos;
      in_range_r <= (32'(in_item.item_id) < ID_SPACE);
    end
    if (cmd.fire) begin
      out_r <= out_nxt;
    end
  end

  assign sts.out_busy = out_valid_r && out_stall;
  assign sts.clr_last = (clr_addr_r == IW'(ID_SPACE - 1));
  assign out_valid    = out_valid_r;
  assign out_item     = out_r;

endmodule

### src/sparse_set_engine_top.sv
// Sparse set engine top level: controller plus datapath.
// Depends on sse_pkg, sse_ctrl, sse_dpath (and sse_ram below it).
//
// Holds a set of ids below ID_SPACE as a sparse set with swap-remove: a
// membership memory, an id-to-position map and a dense list, each a
// simple dual-port RAM (one write port, one read port) with registered read.
// Every transaction gives exactly one result. For each item, the accept cycle
// issues the reads of all three memories, and the look state, once the output
// register is free, forms the result and performs every write at once; no new
// item is accepted before that. The result sits in an output register, so a
// new item can be taken while it waits. After reset the membership memory is
// swept clear, one entry a cycle, for all ids; in_stall is high meanwhile.
module sparse_set_engine_top #(
  parameter int ID_SPACE = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sse_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output sse_pkg::out_item_t out_item
);
  import sse_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  sse_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  sse_dpath #(.ID_SPACE(ID_SPACE)) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  a_load_then_fire: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !cmd.load && !cmd.clr)
    else $error("transaction accepted while previous one in flight");

  a_fire_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fire |=> out_valid)
    else $error("result not presented after issue");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> in_stall && !cmd.fire)
    else $error("activity during clearing pass");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_item.element_count) <= ID_SPACE))
    else $error("element count beyond id space");

endmodule
